>>> rtl/rlt_pkg.sv
`default_nettype none

package rlt_pkg;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_BUSY      = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_NOT_OWNER = 3'd3;
  localparam logic [2:0] STS_SATURATED = 3'd4;

  localparam logic       OP_ACQUIRE = 1'b0;
  localparam logic       OP_RELEASE = 1'b1;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic        opcode;
    logic [63:0] lock_id;
    logic [15:0] client_id;
    logic [31:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] hold_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0] lock_id;
    logic [15:0] client;
    logic [31:0] thread;
    logic [7:0]  count;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> rtl/reentrant_lock_table_core.sv
`default_nettype none

// Reentrant lock table: keeps up to TABLE_ENTRIES held locks, each with an
// owner (client, thread) and a hold count.
// Request channel: req carries opcode, lock_id, client_id and thread_id; a
// transfer happens at a rising edge with start high and busy low.
// Result channel: done pulses for one cycle with rsp (status, hold_count)
// valid in that cycle; the receiver has no way to stall it and must take it.
// Each request walks the table one entry a cycle through the single read
// port of the entry memory, so the scan sets the timing: the scan is
// followed by a wait state and an apply state, and the result strobe is
// registered from apply. busy stays high through scan, wait and apply, so
// a new request is not taken until the current one has applied its result.
// Reset clears all entry valid bits at once, so the table is empty and ready
// for a request in the first cycle after reset; no result is pending.
// Status codes: ok, busy (held by another owner), table full, not owner or
// unknown lock, count saturated.
module reentrant_lock_table_core import rlt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rlt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  rlt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .rsp  (rsp)
  );

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_full_has_no_count: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STS_FULL) |-> (rsp.hold_count == 8'd0))
    else $error("table full result with a non-zero count");
`endif

endmodule

`default_nettype wire

>>> rtl/rlt_ctrl.sv
`default_nettype none

module rlt_ctrl import rlt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.read = 1'b1;
        if (sts.scan_last) begin
          state_next = S_WAIT;
        end
      end
      // last read data is compared here
      S_WAIT: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scan_ends_in_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.scan_last) |=> (state == S_WAIT))
    else $error("scan did not hand over to the wait state");

  a_apply_follows_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |=> cmd.apply)
    else $error("apply did not follow the wait state");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_SCAN))
    else $error("load did not start a scan");
`endif

endmodule

`default_nettype wire

>>> rtl/rlt_datapath.sv
`default_nettype none

module rlt_datapath import rlt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_t      req,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts,
  output logic           done,
  output rsp_t           rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  req_t             req_q;
  logic [IDX_W-1:0] idx;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;
  logic             rd_valid;

  logic             found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_entry;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             owner;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             set_v;
  logic             clr_v;
  rsp_t             rsp_next;

  assign sts.scan_last = (idx == LAST_IDX);

  // table storage, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (set_v) begin
        valid[wr_addr] <= 1'b1;
      end
      if (clr_v) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.read) begin
      rd_idx   <= idx;
      rd_valid <= valid[idx];
    end
  end

  // scan counter and search results
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      rd_pend <= cmd.read;
      if (cmd.load) begin
        idx        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.read) begin
        idx <= idx + IDX_W'(1);
      end
      if (rd_pend) begin
        if (rd_valid && rd_data.lock_id == req_q.lock_id && !found) begin
          found <= 1'b1;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (rd_valid && rd_data.lock_id == req_q.lock_id && !found) begin
        hit_idx   <= rd_idx;
        hit_entry <= rd_data;
      end
      if (!rd_valid && !free_found) begin
        free_idx <= rd_idx;
      end
    end
  end

  assign owner = (hit_entry.client == req_q.client_id) &&
                 (hit_entry.thread == req_q.thread_id);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = hit_idx;
    wr_data  = hit_entry;
    set_v    = 1'b0;
    clr_v    = 1'b0;
    rsp_next = '0;
    if (req_q.opcode == OP_ACQUIRE) begin
      if (!found) begin
        if (!free_found) begin
          rsp_next.status = STS_FULL;
        end else begin
          wr_en              = cmd.apply;
          set_v              = cmd.apply;
          wr_addr            = free_idx;
          wr_data.lock_id    = req_q.lock_id;
          wr_data.client     = req_q.client_id;
          wr_data.thread     = req_q.thread_id;
          wr_data.count      = 8'd1;
          rsp_next.status    = STS_OK;
          rsp_next.hold_count = 8'd1;
        end
      end else if (!owner) begin
        rsp_next.status     = STS_BUSY;
        rsp_next.hold_count = hit_entry.count;
      end else if (hit_entry.count == COUNT_MAX) begin
        rsp_next.status     = STS_SATURATED;
        rsp_next.hold_count = COUNT_MAX;
      end else begin
        wr_en               = cmd.apply;
        wr_data.count       = hit_entry.count + 8'd1;
        rsp_next.status     = STS_OK;
        rsp_next.hold_count = hit_entry.count + 8'd1;
      end
    end else begin
      if (!found) begin
        rsp_next.status = STS_NOT_OWNER;
      end else if (!owner) begin
        rsp_next.status     = STS_NOT_OWNER;
        rsp_next.hold_count = hit_entry.count;
      end else if (hit_entry.count <= 8'd1) begin
        // final release frees the entry
        clr_v           = cmd.apply;
        rsp_next.status = STS_OK;
      end else begin
        wr_en               = cmd.apply;
        wr_data.count       = hit_entry.count - 8'd1;
        rsp_next.status     = STS_OK;
        rsp_next.hold_count = hit_entry.count - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.apply;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_no_set_and_clear: assert property (@(posedge clk) disable iff (rst)
    !(set_v && clr_v))
    else $error("entry allocated and freed in one transfer");

  a_alloc_needs_free: assert property (@(posedge clk) disable iff (rst)
    set_v |-> (free_found && !found))
    else $error("allocation without a free entry or with a live match");

  a_clear_needs_hit: assert property (@(posedge clk) disable iff (rst)
    clr_v |-> (found && valid[hit_idx]))
    else $error("freeing an entry that is not held");
`endif

endmodule

`default_nettype wire
